// ----- hw/rtl/pr2d_pkg.sv -----
// shared types, constants and the arctangent table of the point rotation unit
package pr2d_pkg;

    // default coordinate width and cordic depth
    localparam int COORD_WIDTH_DEF   = 32;
    localparam int CORDIC_STAGES_DEF = 24;

    // binary angle width, 2^32 is one full turn
    localparam int ANGLE_W = 32;

    // cordic x/y datapath: 32 fraction bits plus headroom for gain and truncation
    localparam int CORDIC_W = 36;

    // start x: inverse cordic gain with 32 fraction bits
    localparam logic signed [CORDIC_W-1:0] GAIN_K = 36'sh0_9B74_EDA8;

    // quadrant that the angle was folded from
    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } t_quad;

    // atan(2^-k) as a binary angle
    function automatic logic [ANGLE_W-1:0] atan_entry(input logic [4:0] k);
        logic [ANGLE_W-1:0] t;
        case (k)
            5'd0:    t = 32'h2000_0000;
            5'd1:    t = 32'h12E4_051E;
            5'd2:    t = 32'h09FB_385B;
            5'd3:    t = 32'h0511_11D4;
            5'd4:    t = 32'h028B_0D43;
            5'd5:    t = 32'h0145_D7E1;
            5'd6:    t = 32'h00A2_F61E;
            5'd7:    t = 32'h0051_7C55;
            5'd8:    t = 32'h0028_BE53;
            5'd9:    t = 32'h0014_5F2F;
            5'd10:   t = 32'h000A_2F98;
            5'd11:   t = 32'h0005_17CC;
            5'd12:   t = 32'h0002_8BE6;
            5'd13:   t = 32'h0001_45F3;
            5'd14:   t = 32'h0000_A2FA;
            5'd15:   t = 32'h0000_517D;
            5'd16:   t = 32'h0000_28BE;
            5'd17:   t = 32'h0000_145F;
            5'd18:   t = 32'h0000_0A30;
            5'd19:   t = 32'h0000_0518;
            5'd20:   t = 32'h0000_028C;
            5'd21:   t = 32'h0000_0146;
            5'd22:   t = 32'h0000_00A3;
            5'd23:   t = 32'h0000_0051;
            5'd24:   t = 32'h0000_0029;
            5'd25:   t = 32'h0000_0014;
            5'd26:   t = 32'h0000_000A;
            5'd27:   t = 32'h0000_0005;
            5'd28:   t = 32'h0000_0003;
            5'd29:   t = 32'h0000_0001;
            5'd30:   t = 32'h0000_0001;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

// ----- hw/rtl/point_rotation_2d_unit.sv -----
// top level of the 2d point rotation unit: angle fold, cordic pipeline, rotate stage
// start reaches o_valid through the input register, the cordic pipeline and the rotate stages
// throughput: one point per cycle; the pipeline never stalls, so busy stays low
// each result is shown for one cycle on o_valid and must be taken then
// synchronous active-low reset clears all valid bits; items in flight are dropped
module point_rotation_2d_unit #(
    parameter int COORD_WIDTH   = pr2d_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES = pr2d_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [COORD_WIDTH-1:0]       i_px,
    input  logic signed [COORD_WIDTH-1:0]       i_py,
    input  logic        [pr2d_pkg::ANGLE_W-1:0] i_angle,
    output logic                                o_valid,
    output logic signed [COORD_WIDTH-1:0]       o_rx,
    output logic signed [COORD_WIDTH-1:0]       o_ry
);

    localparam int W      = COORD_WIDTH;
    localparam int AW     = pr2d_pkg::ANGLE_W;
    localparam int CW     = pr2d_pkg::CORDIC_W;
    localparam int SIDE_W = 2 + 2 * W;
    localparam int LAT    = CORDIC_STAGES + 5;

    // never stalls
    assign busy = 1'b0;

    // fold the angle into one quadrant around zero
    logic [AW-1:0]        n_bias;
    pr2d_pkg::t_quad      n_q;
    logic signed [AW-1:0] n_z;

    always_comb begin
        n_bias = i_angle + {3'b001, {(AW-3){1'b0}}};
        n_q    = pr2d_pkg::t_quad'(n_bias[AW-1:AW-2]);
        n_z    = $signed(i_angle - {n_bias[AW-1:AW-2], {(AW-2){1'b0}}});
    end

    // input register
    logic                 r_v;
    pr2d_pkg::t_quad      r_q;
    logic signed [AW-1:0] r_z;
    logic signed [W-1:0]  r_px;
    logic signed [W-1:0]  r_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q  <= n_q;
        r_z  <= n_z;
        r_px <= i_px;
        r_py <= i_py;
    end

    // cordic pipeline, point and quadrant ride along
    logic                 cd_valid;
    logic signed [CW-1:0] cd_x;
    logic signed [CW-1:0] cd_y;
    logic [SIDE_W-1:0]    cd_side;

    pr2d_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (SIDE_W)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v),
        .i_z     (r_z),
        .i_side  ({r_q, r_px, r_py}),
        .o_valid (cd_valid),
        .o_x     (cd_x),
        .o_y     (cd_y),
        .o_side  (cd_side)
    );

    // coefficients, products and saturation
    pr2d_rotate #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cd_valid),
        .i_x     (cd_x),
        .i_y     (cd_y),
        .i_q     (pr2d_pkg::t_quad'(cd_side[SIDE_W-1:SIDE_W-2])),
        .i_px    ($signed(cd_side[2*W-1:W])),
        .i_py    ($signed(cd_side[W-1:0])),
        .o_valid (o_valid),
        .o_rx    (o_rx),
        .o_ry    (o_ry)
    );

    // a result only comes from a matching earlier transfer on start
    a_valid_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without matching transfer");

    // the origin stays at the origin under any rotation
    a_origin_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_px == '0, LAT) && $past(i_py == '0, LAT))
            |-> (o_rx == '0 && o_ry == '0))
        else $error("origin moved by rotation");

    // cordic output valid leads the result strobe by the rotate depth
    a_cordic_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(cd_valid, 4))
        else $error("rotate stage valid out of step");

endmodule

// ----- hw/rtl/pr2d_cordic.sv -----
// pipelined rotation-mode cordic, one micro-rotation per register stage
module pr2d_cordic #(
    parameter int STAGES = pr2d_pkg::CORDIC_STAGES_DEF,
    parameter int SIDE_W = 2 + 2 * pr2d_pkg::COORD_WIDTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  logic signed [pr2d_pkg::ANGLE_W-1:0]     i_z,
    input  logic        [SIDE_W-1:0]                i_side,
    output logic                                    o_valid,
    output logic signed [pr2d_pkg::CORDIC_W-1:0]    o_x,
    output logic signed [pr2d_pkg::CORDIC_W-1:0]    o_y,
    output logic        [SIDE_W-1:0]                o_side
);

    localparam int CW = pr2d_pkg::CORDIC_W;
    localparam int AW = pr2d_pkg::ANGLE_W;

    // stage registers, entry g holds the result of micro-rotation g
    logic                 r_v    [0:STAGES-1];
    logic signed [CW-1:0] r_x    [0:STAGES-1];
    logic signed [CW-1:0] r_y    [0:STAGES-1];
    logic signed [AW-1:0] r_z    [0:STAGES-1];
    logic [SIDE_W-1:0]    r_side [0:STAGES-1];

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        localparam int K = g % 32;

        logic                 a_v;
        logic signed [CW-1:0] a_x;
        logic signed [CW-1:0] a_y;
        logic signed [AW-1:0] a_z;
        logic [SIDE_W-1:0]    a_side;
        logic signed [CW-1:0] n_x;
        logic signed [CW-1:0] n_y;
        logic signed [AW-1:0] n_z;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [AW-1:0] t;

        // stage input: block input or previous stage
        if (g == 0) begin : g_first
            assign a_v    = i_valid;
            assign a_x    = pr2d_pkg::GAIN_K;
            assign a_y    = '0;
            assign a_z    = i_z;
            assign a_side = i_side;
        end else begin : g_next
            assign a_v    = r_v[g-1];
            assign a_x    = r_x[g-1];
            assign a_y    = r_y[g-1];
            assign a_z    = r_z[g-1];
            assign a_side = r_side[g-1];
        end

        // micro-rotation toward zero residual angle
        always_comb begin
            dx = a_y >>> K;
            dy = a_x >>> K;
            t  = $signed(pr2d_pkg::atan_entry(5'(K)));
            if (!a_z[AW-1]) begin
                n_x = a_x - dx;
                n_y = a_y + dy;
                n_z = a_z - t;
            end else begin
                n_x = a_x + dx;
                n_y = a_y - dy;
                n_z = a_z + t;
            end
        end

        // valid bit
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else begin
                r_v[g] <= a_v;
            end
        end

        // payload
        always_ff @(posedge i_clk) begin
            r_x[g]    <= n_x;
            r_y[g]    <= n_y;
            r_z[g]    <= n_z;
            r_side[g] <= a_side;
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_x     = r_x[STAGES-1];
    assign o_y     = r_y[STAGES-1];
    assign o_side  = r_side[STAGES-1];

endmodule

// ----- hw/rtl/pr2d_rotate.sv -----
// coefficient rounding, quadrant unfold, products, rounding and saturation
module pr2d_rotate #(
    parameter int COORD_WIDTH = pr2d_pkg::COORD_WIDTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  logic signed [pr2d_pkg::CORDIC_W-1:0]    i_x,
    input  logic signed [pr2d_pkg::CORDIC_W-1:0]    i_y,
    input  pr2d_pkg::t_quad                         i_q,
    input  logic signed [COORD_WIDTH-1:0]           i_px,
    input  logic signed [COORD_WIDTH-1:0]           i_py,
    output logic                                    o_valid,
    output logic signed [COORD_WIDTH-1:0]           o_rx,
    output logic signed [COORD_WIDTH-1:0]           o_ry
);

    localparam int W    = COORD_WIDTH;
    localparam int CW   = pr2d_pkg::CORDIC_W;
    // coefficient fraction bits, keeps each product within 64 bits
    localparam int COEF_FRAC = ((62 - W) < 30) ? (62 - W) : 30;
    localparam int SH   = 32 - COEF_FRAC;
    localparam int CCW  = COEF_FRAC + 2;
    localparam int PW   = CCW + W;
    localparam int SW   = PW + 1;
    localparam int RW   = SW - COEF_FRAC;

    localparam logic signed [CW-1:0] C_ROUND = CW'(64'sd1 <<< (SH - 1));
    localparam logic signed [SW-1:0] P_ROUND = SW'(64'sd1 <<< (COEF_FRAC - 1));
    localparam logic signed [W-1:0]  SAT_HI  = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  SAT_LO  = {1'b1, {(W-1){1'b0}}};

    // stage a: rounded, unfolded cosine and sine
    logic                  r_va;
    logic signed [CCW-1:0] r_cs;
    logic signed [CCW-1:0] r_sn;
    logic signed [W-1:0]   r_pxa;
    logic signed [W-1:0]   r_pya;
    logic signed [CW-1:0]  c_full;
    logic signed [CW-1:0]  s_full;
    logic signed [CCW-1:0] c_r;
    logic signed [CCW-1:0] s_r;
    logic signed [CCW-1:0] n_cs;
    logic signed [CCW-1:0] n_sn;

    always_comb begin
        c_full = (i_x + C_ROUND) >>> SH;
        s_full = (i_y + C_ROUND) >>> SH;
        c_r    = CCW'(c_full);
        s_r    = CCW'(s_full);
        case (i_q)
            pr2d_pkg::QUAD_0: begin
                n_cs = c_r;
                n_sn = s_r;
            end
            pr2d_pkg::QUAD_90: begin
                n_cs = -s_r;
                n_sn = c_r;
            end
            pr2d_pkg::QUAD_180: begin
                n_cs = -c_r;
                n_sn = -s_r;
            end
            pr2d_pkg::QUAD_270: begin
                n_cs = s_r;
                n_sn = -c_r;
            end
            default: begin
                n_cs = c_r;
                n_sn = s_r;
            end
        endcase
    end

    // stage b: the four products
    logic                 r_vb;
    logic signed [PW-1:0] r_p_cx;
    logic signed [PW-1:0] r_p_sy;
    logic signed [PW-1:0] r_p_cy;
    logic signed [PW-1:0] r_p_sx;

    // stage c: rounded sums
    logic                 r_vc;
    logic signed [RW-1:0] r_sum_x;
    logic signed [RW-1:0] r_sum_y;
    logic signed [SW-1:0] n_acc_x;
    logic signed [SW-1:0] n_acc_y;
    logic signed [SW-1:0] n_shx;
    logic signed [SW-1:0] n_shy;

    always_comb begin
        n_acc_x = SW'(r_p_cx) + SW'(r_p_sy) + P_ROUND;
        n_acc_y = SW'(r_p_cy) - SW'(r_p_sx) + P_ROUND;
        n_shx   = n_acc_x >>> COEF_FRAC;
        n_shy   = n_acc_y >>> COEF_FRAC;
    end

    // stage d: saturation into the coordinate range
    logic signed [W-1:0] n_rx;
    logic signed [W-1:0] n_ry;

    always_comb begin
        if (r_sum_x > RW'(SAT_HI)) begin
            n_rx = SAT_HI;
        end else if (r_sum_x < RW'(SAT_LO)) begin
            n_rx = SAT_LO;
        end else begin
            n_rx = W'(r_sum_x);
        end
        if (r_sum_y > RW'(SAT_HI)) begin
            n_ry = SAT_HI;
        end else if (r_sum_y < RW'(SAT_LO)) begin
            n_ry = SAT_LO;
        end else begin
            n_ry = W'(r_sum_y);
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
            r_vc    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_va    <= i_valid;
            r_vb    <= r_va;
            r_vc    <= r_vb;
            o_valid <= r_vc;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_cs    <= n_cs;
        r_sn    <= n_sn;
        r_pxa   <= i_px;
        r_pya   <= i_py;
        r_p_cx  <= r_cs * r_pxa;
        r_p_sy  <= r_sn * r_pya;
        r_p_cy  <= r_cs * r_pya;
        r_p_sx  <= r_sn * r_pxa;
        r_sum_x <= RW'(n_shx);
        r_sum_y <= RW'(n_shy);
        o_rx    <= n_rx;
        o_ry    <= n_ry;
    end

endmodule
